/* rtl/iht_pkg.sv */
// shared constants, types and helper functions for the imu heading and tilt block
`default_nettype none
package iht_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int ITER_COUNT        = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;
  localparam int ITER_W            = $clog2(ITER_COUNT);
  localparam int TAB_W             = $clog2(ATAN_ENTRIES);

  localparam int DATA_W  = 16;
  localparam int HEAD_W  = 48;
  localparam int PROD_W  = 34;
  localparam int XY_W    = 36;
  localparam int ANG_W   = 34;
  localparam int XF_W    = 34;
  localparam int XF_LO_W = 17;
  localparam int XF_HI_W = XF_W - XF_LO_W;
  localparam int GAIN_W  = 30;

  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ITER,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_DONE
  } iht_state_t;

  typedef struct packed {
    logic              load;
    logic              head;
    logic              pre;
    logic              iter;
    logic [ITER_W-1:0] idx;
    logic              gain_lo;
    logic              gain_hi;
    logic              finish;
  } iht_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } iht_status_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // angle at lsb pi/2^31 to output lsb pi/2^15, rounded half up, mod 2^16
  function automatic logic [DATA_W-1:0] angle_out(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] s;
    s = a + 34'sd32768;
    return s[31:16];
  endfunction

endpackage
`default_nettype wire

/* rtl/iht_sample_if.sv */
// input channel interface carrying one imu sample per beat
`default_nettype none
interface iht_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gyro_z_rate;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [15:0] elapsed_ms;

  modport source (
    output valid, gyro_z_rate, accel_x, accel_y, accel_z, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, gyro_z_rate, accel_x, accel_y, accel_z, elapsed_ms,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/iht_result_if.sv */
// output channel interface carrying heading and tilt per beat
`default_nettype none
interface iht_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] heading_sum;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;

  modport source (
    output valid, heading_sum, roll_angle, pitch_angle,
    input  ready
  );
  modport sink (
    input  valid, heading_sum, roll_angle, pitch_angle,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/iht_ctrl.sv */
// sequencing state machine for heading update and two cordic passes
`default_nettype none
module iht_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_accept,
  output logic                     in_ready,
  input  wire iht_pkg::iht_status_t sts,
  output iht_pkg::iht_cmd_t        cmd
);

  iht_pkg::iht_state_t             state, state_next;
  logic                            pass, pass_next;
  logic [iht_pkg::ITER_W-1:0]      cnt, cnt_next;
  logic                            cnt_last;

  assign cnt_last = (cnt == iht_pkg::ITER_W'(iht_pkg::ITER_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iht_pkg::ST_IDLE;
      pass  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cnt_next   = cnt;
    case (state)
      iht_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = iht_pkg::ST_PRE;
          pass_next  = 1'b0;
        end
      end
      iht_pkg::ST_PRE: begin
        state_next = iht_pkg::ST_ITER;
        cnt_next   = '0;
      end
      iht_pkg::ST_ITER: begin
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          state_next = pass ? iht_pkg::ST_DONE : iht_pkg::ST_GAIN_LO;
        end
      end
      iht_pkg::ST_GAIN_LO: state_next = iht_pkg::ST_GAIN_HI;
      iht_pkg::ST_GAIN_HI: begin
        state_next = iht_pkg::ST_PRE;
        pass_next  = 1'b1;
      end
      iht_pkg::ST_DONE: begin
        if (!sts.out_blocked) begin
          state_next = iht_pkg::ST_IDLE;
        end
      end
      default: state_next = iht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == iht_pkg::ST_IDLE);
    cmd.load    = in_accept;
    cmd.head    = (state == iht_pkg::ST_PRE) && !pass;
    cmd.pre     = (state == iht_pkg::ST_PRE);
    cmd.iter    = (state == iht_pkg::ST_ITER);
    cmd.idx     = cnt;
    cmd.gain_lo = (state == iht_pkg::ST_GAIN_LO);
    cmd.gain_hi = (state == iht_pkg::ST_GAIN_HI);
    cmd.finish  = (state == iht_pkg::ST_DONE) && !sts.out_blocked;
  end

endmodule
`default_nettype wire

/* rtl/iht_datapath.sv */
// heading accumulator, shared cordic vectoring unit and result register
`default_nettype none
module iht_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire iht_pkg::iht_cmd_t          cmd,
  output iht_pkg::iht_status_t            sts,
  input  wire logic                       cfg_we,
  input  wire logic signed [15:0]         cfg_wdata,
  input  wire logic signed [15:0]         gyro_z_rate,
  input  wire logic signed [15:0]         accel_x,
  input  wire logic signed [15:0]         accel_y,
  input  wire logic signed [15:0]         accel_z,
  input  wire logic        [15:0]         elapsed_ms,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [47:0]              heading_sum,
  output logic signed [15:0]              roll_angle,
  output logic signed [15:0]              pitch_angle
);

  localparam int XY_W  = iht_pkg::XY_W;
  localparam int ANG_W = iht_pkg::ANG_W;

  logic signed [15:0]                   gyro_z_bias;
  logic signed [iht_pkg::HEAD_W-1:0]    head_acc;
  logic signed [iht_pkg::PROD_W-1:0]    head_prod;
  logic signed [15:0]                   nax;
  logic signed [XY_W-1:0]               x, y;
  logic signed [ANG_W-1:0]              ang;
  logic                                 zero;
  logic [15:0]                          roll;
  logic [iht_pkg::XF_LO_W+iht_pkg::GAIN_W-1:0] p_lo;
  logic [iht_pkg::XF_HI_W-1:0]          xf_hi;

  logic signed [16:0]                   rate_c;
  logic signed [iht_pkg::HEAD_W:0]      head_sum;
  logic signed [XY_W-1:0]               dx, dy;
  logic [iht_pkg::XF_W-1:0]             xf;
  logic [iht_pkg::XF_HI_W+iht_pkg::GAIN_W-1:0] p_hi;
  logic [63:0]                          gain_sum;
  logic signed [ANG_W-1:0]              ang_fin;

  always_comb begin
    rate_c   = {gyro_z_rate[15], gyro_z_rate} - {gyro_z_bias[15], gyro_z_bias};
    head_sum = {head_acc[iht_pkg::HEAD_W-1], head_acc}
             + {{(iht_pkg::HEAD_W + 1 - iht_pkg::PROD_W){head_prod[iht_pkg::PROD_W-1]}},
                head_prod};
    dx       = y >>> cmd.idx;
    dy       = x >>> cmd.idx;
    xf       = x[XY_W-1] ? '0 : x[iht_pkg::XF_W-1:0];
    p_hi     = xf_hi * iht_pkg::INV_GAIN;
    gain_sum = {p_hi, {iht_pkg::XF_LO_W{1'b0}}} + 64'(p_lo) + 64'd536870912;
    ang_fin  = zero ? '0 : ang;
    sts.out_blocked = out_valid && !out_ready;
  end

  // bias register and heading accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_z_bias <= '0;
      head_acc    <= '0;
    end else begin
      if (cfg_we) begin
        gyro_z_bias <= cfg_wdata;
      end
      if (cmd.head) begin
        if (head_sum[iht_pkg::HEAD_W] != head_sum[iht_pkg::HEAD_W-1]) begin
          head_acc <= head_sum[iht_pkg::HEAD_W] ?
                      {1'b1, {(iht_pkg::HEAD_W-1){1'b0}}} :
                      {1'b0, {(iht_pkg::HEAD_W-1){1'b1}}};
        end else begin
          head_acc <= head_sum[iht_pkg::HEAD_W-1:0];
        end
      end
    end
  end

  // cordic and gain datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      head_prod <= iht_pkg::PROD_W'(rate_c * $signed({1'b0, elapsed_ms}));
      nax       <= (accel_x == 16'sh8000) ? 16'sh7fff : -accel_x;
      x         <= {{(XY_W-32){accel_z[15]}}, accel_z, 16'h0000};
      y         <= {{(XY_W-32){accel_y[15]}}, accel_y, 16'h0000};
    end else if (cmd.pre) begin
      if (x == '0 && y == '0) begin
        zero <= 1'b1;
        ang  <= '0;
      end else begin
        zero <= 1'b0;
        if (x[XY_W-1]) begin
          if (!y[XY_W-1]) begin
            x   <= y;
            y   <= -x;
            ang <= iht_pkg::ANG_QUARTER;
          end else begin
            x   <= -y;
            y   <= x;
            ang <= -iht_pkg::ANG_QUARTER;
          end
        end else begin
          ang <= '0;
        end
      end
    end else if (cmd.iter) begin
      if (!y[XY_W-1]) begin
        x   <= x + dx;
        y   <= y - dy;
        ang <= ang + iht_pkg::atan_entry(iht_pkg::TAB_W'(cmd.idx));
      end else begin
        x   <= x - dx;
        y   <= y + dy;
        ang <= ang - iht_pkg::atan_entry(iht_pkg::TAB_W'(cmd.idx));
      end
    end else if (cmd.gain_lo) begin
      p_lo  <= xf[iht_pkg::XF_LO_W-1:0] * iht_pkg::INV_GAIN;
      xf_hi <= xf[iht_pkg::XF_W-1:iht_pkg::XF_LO_W];
      roll  <= iht_pkg::angle_out(ang_fin);
    end else if (cmd.gain_hi) begin
      // magnitude of (y,z) at scale 2^16, gain removed
      x <= {{(XY_W-34){1'b0}}, gain_sum[63:30]};
      y <= {{(XY_W-32){nax[15]}}, nax, 16'h0000};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      heading_sum <= head_acc;
      roll_angle  <= roll;
      pitch_angle <= iht_pkg::angle_out(ang_fin);
    end
  end

endmodule
`default_nettype wire

/* rtl/imu_heading_and_tilt.sv */
// top level: gyro heading integration and accelerometer roll/pitch
`default_nettype none
// one sample in work at a time: the single shared cordic unit does the roll pass and then
//   the pitch pass, one rotation per cycle
// a finished result sits in the output register; the next sample is taken meanwhile
// reset: synchronous, clears the heading accumulator, the bias register and all
//   handshake state; ready is high the cycle after reset drops
module imu_heading_and_tilt (
  input  wire logic          clk,
  input  wire logic          rst,
  iht_sample_if.sink         sample,
  iht_result_if.source       result,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);

  iht_pkg::iht_cmd_t    cmd;
  iht_pkg::iht_status_t sts;
  logic                 in_ready;
  logic                 in_accept;

  // a sample beat moves when the controller sits idle
  assign in_accept    = sample.valid && in_ready;
  assign sample.ready = in_ready;

  // controller: idle, pre-rotate, iterate, gain correct, then pre-rotate and iterate for pitch and hand over the result
  iht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: heading multiply-accumulate with saturation, cordic vectoring,
  // split gain multiply and the result register
  iht_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .gyro_z_rate (sample.gyro_z_rate),
    .accel_x     (sample.accel_x),
    .accel_y     (sample.accel_y),
    .accel_z     (sample.accel_z),
    .elapsed_ms  (sample.elapsed_ms),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .heading_sum (result.heading_sum),
    .roll_angle  (result.roll_angle),
    .pitch_angle (result.pitch_angle)
  );

endmodule
`default_nettype wire

/* rtl/iht_checker.sv */
// port-level assertions for the imu heading and tilt block, bound to the top
`default_nettype none
module iht_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               sample_valid,
  input wire logic               sample_ready,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire logic signed [47:0] heading_sum,
  input wire logic signed [15:0] pitch_angle
);

  // one sample in flight: ready drops right after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample taken while previous one still in work");

  // after reset the block is empty and ready
  assert property (@(posedge clk)
    rst |=> (!result_valid && sample_ready))
    else $error("block not idle after reset");

  // pitch stays within a quarter turn
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pitch_angle >= -16'sd16384 && pitch_angle <= 16'sd16384))
    else $error("pitch outside quarter turn");

  // stalled result holds its heading
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(heading_sum)))
    else $error("stalled result changed");

endmodule

bind imu_heading_and_tilt iht_checker u_iht_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .heading_sum  (result.heading_sum),
  .pitch_angle  (result.pitch_angle)
);
`default_nettype wire
